>>> hw/rtl/bsdf_pkg.sv
// ----------------------------------------------------------------------------
// Byte split delta filter package
// Register map, field widths and fixed constants shared by the filter modules.
// ----------------------------------------------------------------------------
package bsdf_pkg;

  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int BUF_LEN_W  = 21;
  localparam int OUT_ADDR_W = 20;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_SEED   = 2'd2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_BIAS      = 8'h80;
  localparam logic [BYTE_W-1:0] ODD_SEED_RESET = 8'h80;

endpackage

>>> hw/rtl/bsdf_cfg.sv
// ----------------------------------------------------------------------------
// Byte split delta filter configuration registers
// APB register file for mode, buffer length and odd seed, with the effective
// length and the half point precomputed on each length write.
// ----------------------------------------------------------------------------
module bsdf_cfg #(
  parameter int MAX_LENGTH = 1048576,
  parameter int LEN_W      = 21
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsdf_pkg::PADDR_W-1:0]      paddr,
  input  logic [bsdf_pkg::PDATA_W-1:0]      pwdata,
  output logic [bsdf_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output logic                              mode,
  output logic [bsdf_pkg::BYTE_W-1:0]       odd_seed,
  output logic [LEN_W-1:0]                  eff_len,
  output logic [LEN_W-1:0]                  mid
);

  localparam int CMP_W = (LEN_W > bsdf_pkg::BUF_LEN_W) ? LEN_W : bsdf_pkg::BUF_LEN_W;

  logic [bsdf_pkg::BUF_LEN_W-1:0] buffer_length;
  logic                           wr_en;
  logic [CMP_W-1:0]               wr_len;
  logic [CMP_W-1:0]               max_len;
  logic [CMP_W-1:0]               clamped;
  logic [LEN_W-1:0]               eff_len_next;
  logic [LEN_W-1:0]               mid_next;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign wr_len  = CMP_W'(pwdata[bsdf_pkg::BUF_LEN_W-1:0]);
  assign max_len = CMP_W'(MAX_LENGTH);

  always_comb begin
    if (wr_len == '0) begin
      clamped = CMP_W'(1);
    end else if (wr_len > max_len) begin
      clamped = max_len;
    end else begin
      clamped = wr_len;
    end
    eff_len_next = clamped[LEN_W-1:0];
    mid_next     = (eff_len_next + LEN_W'(1)) >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= bsdf_pkg::MODE_ENCODE;
      buffer_length <= bsdf_pkg::BUF_LEN_W'(1);
      odd_seed      <= bsdf_pkg::ODD_SEED_RESET;
      eff_len       <= LEN_W'(1);
      mid           <= LEN_W'(1);
    end else if (wr_en) begin
      case (paddr[3:2])
        bsdf_pkg::REG_MODE: begin
          mode <= pwdata[0];
        end
        bsdf_pkg::REG_LENGTH: begin
          buffer_length <= pwdata[bsdf_pkg::BUF_LEN_W-1:0];
          eff_len       <= eff_len_next;
          mid           <= mid_next;
        end
        bsdf_pkg::REG_SEED: begin
          odd_seed <= pwdata[bsdf_pkg::BYTE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bsdf_pkg::REG_MODE:   prdata = bsdf_pkg::PDATA_W'(mode);
      bsdf_pkg::REG_LENGTH: prdata = bsdf_pkg::PDATA_W'(buffer_length);
      bsdf_pkg::REG_SEED:   prdata = bsdf_pkg::PDATA_W'(odd_seed);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/bsdf_core.sv
// ----------------------------------------------------------------------------
// Byte split delta filter datapath
// Input register, predictor and position state, delta and address logic, and
// the result register.
// ----------------------------------------------------------------------------
module bsdf_core #(
  parameter int POS_W = 20,
  parameter int LEN_W = 21
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mode,
  input  logic [bsdf_pkg::BYTE_W-1:0]        odd_seed,
  input  logic [LEN_W-1:0]                   eff_len,
  input  logic [LEN_W-1:0]                   mid,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bsdf_pkg::BYTE_W-1:0]        in_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bsdf_pkg::BYTE_W-1:0]        out_byte,
  output logic [bsdf_pkg::OUT_ADDR_W-1:0]    out_address,
  output logic                               out_last
);

  localparam int AW = (LEN_W + 1 > bsdf_pkg::OUT_ADDR_W) ? LEN_W + 1 : bsdf_pkg::OUT_ADDR_W;

  logic                        s1_valid;
  logic [bsdf_pkg::BYTE_W-1:0] s1_byte;
  logic                        advance;

  logic [POS_W-1:0]            position;
  logic [bsdf_pkg::BYTE_W-1:0] even_pred;
  logic [bsdf_pkg::BYTE_W-1:0] odd_pred;

  logic [bsdf_pkg::BYTE_W-1:0] ep;
  logic [bsdf_pkg::BYTE_W-1:0] op;
  logic                        is_odd;
  logic [bsdf_pkg::BYTE_W-1:0] res;
  logic [AW-1:0]               addr;
  logic                        last_next;
  logic [POS_W-1:0]            position_next;
  logic [bsdf_pkg::BYTE_W-1:0] even_pred_next;
  logic [bsdf_pkg::BYTE_W-1:0] odd_pred_next;

  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;

  always_comb begin
    ep     = (position == '0) ? bsdf_pkg::BYTE_BIAS : even_pred;
    op     = (position == '0) ? odd_seed : odd_pred;
    is_odd = position[0];
    even_pred_next = ep;
    odd_pred_next  = op;
    if (mode == bsdf_pkg::MODE_ENCODE) begin
      if (!is_odd) begin
        res            = (s1_byte - ep) ^ bsdf_pkg::BYTE_BIAS;
        even_pred_next = s1_byte;
        addr           = AW'(position >> 1);
      end else begin
        res           = (s1_byte - op) ^ bsdf_pkg::BYTE_BIAS;
        odd_pred_next = s1_byte;
        addr          = AW'(mid) + AW'(position >> 1);
      end
    end else begin
      res            = ep + s1_byte - bsdf_pkg::BYTE_BIAS;
      even_pred_next = res;
      if (LEN_W'(position) < mid) begin
        addr = AW'(position) << 1;
      end else begin
        addr = ((AW'(position) - AW'(mid)) << 1) | AW'(1);
      end
    end
    last_next     = (LEN_W'(position) + LEN_W'(1)) >= eff_len;
    position_next = last_next ? '0 : position + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      position  <= '0;
      even_pred <= bsdf_pkg::BYTE_BIAS;
      odd_pred  <= bsdf_pkg::ODD_SEED_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        position  <= position_next;
        even_pred <= even_pred_next;
        odd_pred  <= odd_pred_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= in_byte;
    end
    if (advance) begin
      out_byte    <= res;
      out_address <= addr[bsdf_pkg::OUT_ADDR_W-1:0];
      out_last    <= last_next;
    end
  end

endmodule

>>> hw/rtl/byte_split_delta_filter.sv
// ----------------------------------------------------------------------------
// Byte split delta filter
// Streaming byte filter that splits a buffer into even and odd halves with
// delta coding before compression, and rebuilds it after decompression.
// ----------------------------------------------------------------------------
// Set mode, buffer_length and odd_seed over the APB port while the block is
// idle, then stream the buffer's bytes in on the input channel, one request
// per byte. Each input request gives exactly one output request carrying the
// filtered or reconstructed byte, its address in the output buffer and a
// last flag on the final byte, after which the next buffer starts.
// The accepted byte is held in the input register and its result is shown
// from the result register once the input register advances. The block
// takes one byte every cycle while the receiver does not stall, limited by
// the 8-bit byte and address arithmetic between the two registers.
// When the receiver stalls, the result register holds its request and the
// input register absorbs one more byte before the input is stalled.
// Reset empties both registers, restores the register defaults (encode mode,
// length one, odd seed 128) and starts a new buffer at position zero.
// ----------------------------------------------------------------------------
module byte_split_delta_filter #(
  parameter int MAX_LENGTH = 1048576
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsdf_pkg::PADDR_W-1:0]       paddr,
  input  logic [bsdf_pkg::PDATA_W-1:0]       pwdata,
  output logic [bsdf_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bsdf_pkg::BYTE_W-1:0]        data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bsdf_pkg::BYTE_W-1:0]        out_byte,
  output logic [bsdf_pkg::OUT_ADDR_W-1:0]    out_address,
  output logic                               last
);

  localparam int POS_W = $clog2(MAX_LENGTH);
  localparam int LEN_W = POS_W + 1;

  logic                        mode;
  logic [bsdf_pkg::BYTE_W-1:0] odd_seed;
  logic [LEN_W-1:0]            eff_len;
  logic [LEN_W-1:0]            mid;

  bsdf_cfg #(
    .MAX_LENGTH (MAX_LENGTH),
    .LEN_W      (LEN_W)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .mode     (mode),
    .odd_seed (odd_seed),
    .eff_len  (eff_len),
    .mid      (mid)
  );

  bsdf_core #(
    .POS_W (POS_W),
    .LEN_W (LEN_W)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .odd_seed    (odd_seed),
    .eff_len     (eff_len),
    .mid         (mid),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_address (out_address),
    .out_last    (last)
  );

endmodule
